// ----- design/cba_pkg.sv -----
// Shared widths, codes and handshake structs of the contiguous block allocator.
package cba_pkg;

    localparam int ID_W       = 16;
    localparam int SIZE_W     = 24;
    localparam int BB_W       = 16;
    localparam int TOTAL_W    = 11;
    localparam int STATUS_W   = 3;
    localparam int START_W    = 10;
    localparam int LEN_W      = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [LEN_W-1:0]      LEN_MAX     = 11'd2047;
    localparam logic [BB_W-1:0]       BB_RESET    = 16'd512;
    localparam logic [TOTAL_W-1:0]    TOTAL_RESET = 11'd1024;

    localparam logic [CFG_IDX_W-1:0]  REG_BLOCK_BYTES  = 2'd0;
    localparam logic [CFG_IDX_W-1:0]  REG_TOTAL_BLOCKS = 2'd1;

    localparam logic                  FUNC_REMOVE = 1'b1;

    localparam logic [STATUS_W-1:0]   ST_ALLOC     = 3'd0;
    localparam logic [STATUS_W-1:0]   ST_QUEUED    = 3'd1;
    localparam logic [STATUS_W-1:0]   ST_DROPPED   = 3'd2;
    localparam logic [STATUS_W-1:0]   ST_REMOVED   = 3'd3;
    localparam logic [STATUS_W-1:0]   ST_NOT_FOUND = 3'd4;
    localparam logic [STATUS_W-1:0]   ST_PLACED    = 3'd5;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ID_W-1:0]     id;
        logic [START_W-1:0]  start;
        logic [LEN_W-1:0]    len;
        logic                last;
    } res_t;

    // Commands from the sequencer to the datapath
    typedef struct packed {
        logic clr_en;
        logic cap_in;
        logic div_go;
        logic slot_step;
        logic run_step;
        logic mark_step;
        logic dir_wr;
        logic retry;
        logic enq;
        logic rm_step;
        logic rm_chk;
        logic free_step;
        logic rm_done;
        logic q_ld;
        logic q_next;
        logic cmp_rd;
        logic cmp_wr;
        logic cmp_done;
        logic out_sel2;
    } cmd_t;

    // Status from the datapath to the sequencer
    typedef struct packed {
        logic clr_end;
        logic div_busy;
        logic n_zero;
        logic slot_found;
        logic slot_end;
        logic run_found;
        logic run_end;
        logic mark_end;
        logic rm_end;
        logic rm_valid;
        logic rm_match;
        logic free_end;
        logic q_more;
        logic cmp_end;
    } sts_t;

    function automatic logic [LEN_W-1:0] len_sat(input logic [31:0] v);
        len_sat = (v > 32'(LEN_MAX)) ? LEN_MAX : v[LEN_W-1:0];
    endfunction

endpackage

// ----- design/contiguous_block_allocator.sv -----
// Top level of the first-fit contiguous block allocator with directory and wait queue.
//
//  channel | direction | handshake            | beat payload
//  --------+-----------+----------------------+-------------------------------------------
//  in      | input     | in_valid / in_stall  | func, file_id, file_size
//  out     | output    | out_valid / out_stall| status, result_id, start_block,
//          |           |                      | length_blocks, last
//  cfg     | input     | cfg_we               | cfg_index, cfg_data (0 block_bytes, 1 total)
//
//  One request at a time: in_stall stays high from the accepted request until its final
//  result beat is taken, and through the map clear after reset.
//  Add: divide, search for a free directory slot, scan the map (one map bit per cycle),
//  mark the run, record it in the directory.
//  Remove: scan the directory, check each valid entry and free the blocks of each match;
//  then try each queued file as an add, and a placement moves the later entries up.
module contiguous_block_allocator #(
    parameter int NUM_BLOCKS  = 1024,
    parameter int DIR_DEPTH   = 64,
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [cba_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cba_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           func,
    input  logic [cba_pkg::ID_W-1:0]       file_id,
    input  logic [cba_pkg::SIZE_W-1:0]     file_size,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [cba_pkg::STATUS_W-1:0]   status,
    output logic [cba_pkg::ID_W-1:0]       result_id,
    output logic [cba_pkg::START_W-1:0]    start_block,
    output logic [cba_pkg::LEN_W-1:0]      length_blocks,
    output logic                           last
);

    cba_pkg::cmd_t cmd;
    cba_pkg::sts_t sts;
    cba_pkg::res_t res;

    // Sequencer: owns the request flow and the output beats
    cba_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .func      (func),
        .out_stall (out_stall),
        .sts       (sts),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .cmd       (cmd)
    );

    // Datapath: map, directory and queue storage plus the divider
    cba_dp #(
        .NUM_BLOCKS  (NUM_BLOCKS),
        .DIR_DEPTH   (DIR_DEPTH),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .file_id   (file_id),
        .file_size (file_size),
        .cmd       (cmd),
        .sts       (sts),
        .res       (res)
    );

    // Result beats come straight from the held result registers
    assign status        = res.status;
    assign result_id     = res.id;
    assign start_block   = res.start;
    assign length_blocks = res.len;
    assign last          = res.last;

    // Never take a request while a result beat is pending
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(out_valid && !in_stall))
        else $error("input taken while result pending");

    // Only a remove result can be followed by a second beat
    a_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !last) |->
            (status == cba_pkg::ST_REMOVED || status == cba_pkg::ST_NOT_FOUND))
        else $error("non-final beat with wrong status");

    // A non-final beat taken is followed at once by the placed-file beat
    a_second_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !last) |=>
            (out_valid && last && status == cba_pkg::ST_PLACED))
        else $error("missing placed-file beat");

    // A start block only accompanies an allocation
    a_start_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && start_block != '0) |->
            (status == cba_pkg::ST_ALLOC || status == cba_pkg::ST_PLACED))
        else $error("start block on non-allocation result");

endmodule

// ----- design/cba_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module cba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/cba_div.sv -----
// Restoring divider: one quotient bit per cycle, file size by block size.
module cba_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [cba_pkg::SIZE_W-1:0] dividend,
    input  logic [cba_pkg::BB_W-1:0]   divisor,
    output logic                       busy,
    output logic [cba_pkg::SIZE_W-1:0] quotient
);

    localparam int CW = $clog2(cba_pkg::SIZE_W + 1);

    logic [CW-1:0]                cnt_reg;
    logic [cba_pkg::BB_W:0]       rem_reg;
    logic [cba_pkg::SIZE_W-1:0]   quo_reg;
    logic [cba_pkg::BB_W-1:0]     dvs_reg;
    logic [cba_pkg::BB_W:0]       rem_sh;
    logic                         ge;

    assign rem_sh = {rem_reg[cba_pkg::BB_W-1:0], quo_reg[cba_pkg::SIZE_W-1]};
    assign ge     = rem_sh >= {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= CW'(cba_pkg::SIZE_W);
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg <= cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (cnt_reg != '0)
        begin
            rem_reg <= ge ? (rem_sh - {1'b0, dvs_reg}) : rem_sh;
            quo_reg <= {quo_reg[cba_pkg::SIZE_W-2:0], ge};
        end
    end

    assign busy     = cnt_reg != '0;
    assign quotient = quo_reg;

endmodule

// ----- design/cba_dp.sv -----
// Allocator datapath: block map, directory, wait queue, scan counters, results.
module cba_dp #(
    parameter int NUM_BLOCKS  = 1024,
    parameter int DIR_DEPTH   = 64,
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [cba_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cba_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic [cba_pkg::ID_W-1:0]       file_id,
    input  logic [cba_pkg::SIZE_W-1:0]     file_size,
    input  cba_pkg::cmd_t                  cmd,
    output cba_pkg::sts_t                  sts,
    output cba_pkg::res_t                  res
);

    localparam int BW    = $clog2(NUM_BLOCKS);
    localparam int LW    = BW + 1;
    localparam int AW1   = LW + 1;
    localparam int DW    = $clog2(DIR_DEPTH);
    localparam int DCW   = DW + 1;
    localparam int QAW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCW   = $clog2(QUEUE_DEPTH + 1);
    localparam int QCW1  = QCW + 1;
    localparam int FW    = LW + DW;
    localparam int DIR_W = cba_pkg::ID_W + BW + LW;
    localparam int QUE_W = cba_pkg::ID_W + cba_pkg::SIZE_W;

    logic [cba_pkg::BB_W-1:0]    bb_reg;
    logic [cba_pkg::TOTAL_W-1:0] total_reg;
    logic [cba_pkg::ID_W-1:0]    cur_id_reg;
    logic [cba_pkg::SIZE_W-1:0]  cur_size_reg;
    logic [DCW-1:0]              s_reg;
    logic [LW-1:0]               i_reg;
    logic                        pend_reg;
    logic [LW-1:0]               run_reg;
    logic [BW-1:0]               start_reg;
    logic [LW-1:0]               k_reg;
    logic [DCW-1:0]              d_reg;
    logic                        found_reg;
    logic [FW-1:0]               freed_reg;
    logic [QCW-1:0]              q_reg;
    logic [QCW-1:0]              wc_reg;
    logic [DIR_DEPTH-1:0]        valid_reg;
    logic [BW-1:0]               clr_reg;
    cba_pkg::res_t               res1_reg;
    cba_pkg::res_t               res2_reg;

    logic [cba_pkg::SIZE_W-1:0]  n;
    logic                        div_busy;
    logic [cba_pkg::BB_W-1:0]    divisor;
    logic [LW-1:0]               eff;
    logic [LW-1:0]               j;
    logic [LW-1:0]               run_inc;
    logic                        issue;
    logic                        hit;
    logic [BW-1:0]               run_start;
    logic [BW-1:0]               mark_addr;
    logic                        mark_end;

    logic                        map_we;
    logic [BW-1:0]               map_waddr;
    logic                        map_wdata;
    logic                        map_rd;

    logic [DIR_W-1:0]            dir_rd;
    logic [cba_pkg::ID_W-1:0]    dir_file;
    logic [BW-1:0]               dir_start;
    logic [LW-1:0]               dir_len;
    logic [AW1-1:0]              fb;
    logic                        free_in;
    logic                        free_end;
    logic                        rm_match;

    logic                        que_we;
    logic [QAW-1:0]              que_waddr;
    logic [QUE_W-1:0]            que_wdata;
    logic [QAW-1:0]              que_raddr;
    logic [QUE_W-1:0]            que_rd;
    logic                        q_full;

    logic                        slot_found;
    logic                        slot_end;

    assign divisor = (bb_reg == '0) ? cba_pkg::BB_W'(1) : bb_reg;

    cba_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_go),
        .dividend (cur_size_reg),
        .divisor  (divisor),
        .busy     (div_busy),
        .quotient (n)
    );

    always_comb
    begin
        if (32'(total_reg) > NUM_BLOCKS)
        begin
            eff = LW'(NUM_BLOCKS);
        end
        else
        begin
            eff = LW'(total_reg);
        end
    end

    // Map scan: the checked bit is the registered read of the previous read address
    assign j         = i_reg - LW'(1);
    assign run_inc   = run_reg + LW'(1);
    assign issue     = i_reg < eff;
    assign hit       = pend_reg && !map_rd && (cba_pkg::SIZE_W'(run_inc) == n);
    assign run_start = BW'(AW1'(j) + AW1'(1) - AW1'(n[LW-1:0]));
    assign mark_addr = BW'(AW1'(start_reg) + AW1'(k_reg));
    assign mark_end  = k_reg == LW'(n);

    assign dir_file  = dir_rd[DIR_W-1 -: cba_pkg::ID_W];
    assign dir_start = dir_rd[LW +: BW];
    assign dir_len   = dir_rd[LW-1:0];
    assign fb        = AW1'(dir_start) + AW1'(k_reg);
    assign free_in   = fb < AW1'(NUM_BLOCKS);
    assign free_end  = k_reg == dir_len;
    assign rm_match  = dir_file == cur_id_reg;

    assign slot_end   = s_reg == DCW'(DIR_DEPTH);
    assign slot_found = !slot_end && !valid_reg[s_reg[DW-1:0]];

    assign q_full = wc_reg == QCW'(QUEUE_DEPTH);

    always_comb
    begin
        map_we    = 1'b0;
        map_waddr = clr_reg;
        map_wdata = 1'b0;
        if (cmd.clr_en)
        begin
            map_we = 1'b1;
        end
        else if (cmd.mark_step && !mark_end)
        begin
            map_we    = 1'b1;
            map_waddr = mark_addr;
            map_wdata = 1'b1;
        end
        else if (cmd.free_step && !free_end && free_in)
        begin
            map_we    = 1'b1;
            map_waddr = BW'(fb);
        end
    end

    cba_ram #(.WIDTH(1), .DEPTH(NUM_BLOCKS)) u_map (
        .clk   (clk),
        .we    (map_we),
        .waddr (map_waddr),
        .wdata (map_wdata),
        .raddr (i_reg[BW-1:0]),
        .rdata (map_rd)
    );

    cba_ram #(.WIDTH(DIR_W), .DEPTH(DIR_DEPTH)) u_dir (
        .clk   (clk),
        .we    (cmd.dir_wr),
        .waddr (s_reg[DW-1:0]),
        .wdata ({cur_id_reg, start_reg, LW'(n)}),
        .raddr (d_reg[DW-1:0]),
        .rdata (dir_rd)
    );

    assign que_we    = (cmd.enq && !q_full) || cmd.cmp_wr;
    assign que_waddr = cmd.cmp_wr ? q_reg[QAW-1:0] : wc_reg[QAW-1:0];
    assign que_wdata = cmd.cmp_wr ? que_rd : {cur_id_reg, cur_size_reg};
    assign que_raddr = cmd.cmp_rd ? QAW'(q_reg + QCW'(1)) : q_reg[QAW-1:0];

    cba_ram #(.WIDTH(QUE_W), .DEPTH(QUEUE_DEPTH)) u_que (
        .clk   (clk),
        .we    (que_we),
        .waddr (que_waddr),
        .wdata (que_wdata),
        .raddr (que_raddr),
        .rdata (que_rd)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bb_reg    <= cba_pkg::BB_RESET;
            total_reg <= cba_pkg::TOTAL_RESET;
            s_reg     <= '0;
            i_reg     <= '0;
            pend_reg  <= 1'b0;
            run_reg   <= '0;
            k_reg     <= '0;
            d_reg     <= '0;
            found_reg <= 1'b0;
            freed_reg <= '0;
            q_reg     <= '0;
            wc_reg    <= '0;
            valid_reg <= '0;
            clr_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    cba_pkg::REG_BLOCK_BYTES:  bb_reg    <= cfg_data;
                    cba_pkg::REG_TOTAL_BLOCKS: total_reg <= cfg_data[cba_pkg::TOTAL_W-1:0];
                    default: ;
                endcase
            end
            if (cmd.clr_en)
            begin
                clr_reg <= clr_reg + BW'(1);
            end
            if (cmd.cap_in)
            begin
                d_reg     <= '0;
                found_reg <= 1'b0;
                freed_reg <= '0;
            end
            if (cmd.div_go)
            begin
                s_reg    <= '0;
                i_reg    <= '0;
                pend_reg <= 1'b0;
                run_reg  <= '0;
                k_reg    <= '0;
            end
            if (cmd.slot_step && !slot_found && !slot_end)
            begin
                s_reg <= s_reg + DCW'(1);
            end
            if (cmd.run_step)
            begin
                if (issue)
                begin
                    i_reg <= i_reg + LW'(1);
                end
                pend_reg <= issue;
                if (pend_reg)
                begin
                    run_reg <= map_rd ? '0 : run_inc;
                end
            end
            if (cmd.mark_step && !mark_end)
            begin
                k_reg <= k_reg + LW'(1);
            end
            if (cmd.dir_wr)
            begin
                valid_reg[s_reg[DW-1:0]] <= 1'b1;
            end
            if (cmd.enq && !q_full)
            begin
                wc_reg <= wc_reg + QCW'(1);
            end
            if (cmd.rm_step)
            begin
                d_reg <= d_reg + DCW'(1);
            end
            if (cmd.rm_chk)
            begin
                if (rm_match)
                begin
                    found_reg                <= 1'b1;
                    freed_reg                <= freed_reg + FW'(dir_len);
                    valid_reg[d_reg[DW-1:0]] <= 1'b0;
                    k_reg                    <= '0;
                end
                else
                begin
                    d_reg <= d_reg + DCW'(1);
                end
            end
            if (cmd.free_step)
            begin
                if (free_end)
                begin
                    d_reg <= d_reg + DCW'(1);
                end
                else
                begin
                    k_reg <= k_reg + LW'(1);
                end
            end
            if (cmd.rm_done)
            begin
                q_reg <= '0;
            end
            if (cmd.q_next || cmd.cmp_wr)
            begin
                q_reg <= q_reg + QCW'(1);
            end
            if (cmd.cmp_done)
            begin
                wc_reg <= wc_reg - QCW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cap_in)
        begin
            cur_id_reg   <= file_id;
            cur_size_reg <= file_size;
        end
        if (cmd.q_ld)
        begin
            {cur_id_reg, cur_size_reg} <= que_rd;
        end
        if (cmd.div_go)
        begin
            start_reg <= '0;
        end
        if (cmd.run_step && hit)
        begin
            start_reg <= run_start;
        end
        if (cmd.dir_wr)
        begin
            if (cmd.retry)
            begin
                res2_reg.status <= cba_pkg::ST_PLACED;
                res2_reg.id     <= cur_id_reg;
                res2_reg.start  <= cba_pkg::START_W'(start_reg);
                res2_reg.len    <= cba_pkg::len_sat(32'(n));
                res2_reg.last   <= 1'b1;
                res1_reg.last   <= 1'b0;
            end
            else
            begin
                res1_reg.status <= cba_pkg::ST_ALLOC;
                res1_reg.id     <= cur_id_reg;
                res1_reg.start  <= cba_pkg::START_W'(start_reg);
                res1_reg.len    <= cba_pkg::len_sat(32'(n));
                res1_reg.last   <= 1'b1;
            end
        end
        if (cmd.enq)
        begin
            res1_reg.status <= q_full ? cba_pkg::ST_DROPPED : cba_pkg::ST_QUEUED;
            res1_reg.id     <= cur_id_reg;
            res1_reg.start  <= '0;
            res1_reg.len    <= '0;
            res1_reg.last   <= 1'b1;
        end
        if (cmd.rm_done)
        begin
            res1_reg.status <= found_reg ? cba_pkg::ST_REMOVED : cba_pkg::ST_NOT_FOUND;
            res1_reg.id     <= cur_id_reg;
            res1_reg.start  <= '0;
            res1_reg.len    <= found_reg ? cba_pkg::len_sat(32'(freed_reg)) : '0;
            res1_reg.last   <= 1'b1;
        end
    end

    assign sts.clr_end    = clr_reg == BW'(NUM_BLOCKS - 1);
    assign sts.div_busy   = div_busy;
    assign sts.n_zero     = n == '0;
    assign sts.slot_found = slot_found;
    assign sts.slot_end   = slot_end;
    assign sts.run_found  = hit;
    assign sts.run_end    = !pend_reg && !issue;
    assign sts.mark_end   = mark_end;
    assign sts.rm_end     = d_reg == DCW'(DIR_DEPTH);
    assign sts.rm_valid   = valid_reg[d_reg[DW-1:0]];
    assign sts.rm_match   = rm_match;
    assign sts.free_end   = free_end;
    assign sts.q_more     = q_reg < wc_reg;
    assign sts.cmp_end    = (QCW1'(q_reg) + QCW1'(1)) >= QCW1'(wc_reg);

    assign res = cmd.out_sel2 ? res2_reg : res1_reg;

endmodule

// ----- design/cba_ctrl.sv -----
// Allocator sequencer: steps each request through divide, scans, updates and output.
module cba_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic          func,
    input  logic          out_stall,
    input  cba_pkg::sts_t sts,
    output logic          in_stall,
    output logic          out_valid,
    output cba_pkg::cmd_t cmd
);

    localparam logic [4:0] S_CLEAR    = 5'd0;
    localparam logic [4:0] S_IDLE     = 5'd1;
    localparam logic [4:0] S_DIV_GO   = 5'd2;
    localparam logic [4:0] S_DIV_WAIT = 5'd3;
    localparam logic [4:0] S_SLOT     = 5'd4;
    localparam logic [4:0] S_RUN      = 5'd5;
    localparam logic [4:0] S_MARK     = 5'd6;
    localparam logic [4:0] S_DIRW     = 5'd7;
    localparam logic [4:0] S_ADD_FAIL = 5'd8;
    localparam logic [4:0] S_RM_SCAN  = 5'd9;
    localparam logic [4:0] S_RM_CHK   = 5'd10;
    localparam logic [4:0] S_RM_FREE  = 5'd11;
    localparam logic [4:0] S_QTRY     = 5'd12;
    localparam logic [4:0] S_QLD      = 5'd13;
    localparam logic [4:0] S_CMP_RD   = 5'd14;
    localparam logic [4:0] S_CMP_WR   = 5'd15;
    localparam logic [4:0] S_OUT1     = 5'd16;
    localparam logic [4:0] S_OUT2     = 5'd17;

    logic [4:0] state_reg;
    logic [4:0] state_next;
    logic       retry_reg;
    logic       retry_next;
    logic       two_reg;
    logic       two_next;
    logic [4:0] fail_state;

    // Where a failed placement goes: next queue entry, or queue/drop the add
    assign fail_state = retry_reg ? S_QTRY : S_ADD_FAIL;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        retry_next = retry_reg;
        two_next   = two_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_en = 1'b1;
                if (sts.clr_end)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.cap_in = 1'b1;
                    retry_next = 1'b0;
                    two_next   = 1'b0;
                    state_next = (func == cba_pkg::FUNC_REMOVE) ? S_RM_SCAN : S_DIV_GO;
                end
            end
            S_DIV_GO:
            begin
                cmd.div_go = 1'b1;
                state_next = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (!sts.div_busy)
                begin
                    state_next = S_SLOT;
                end
            end
            S_SLOT:
            begin
                cmd.slot_step = 1'b1;
                if (sts.slot_found)
                begin
                    state_next = sts.n_zero ? S_DIRW : S_RUN;
                end
                else if (sts.slot_end)
                begin
                    cmd.q_next = retry_reg;
                    state_next = fail_state;
                end
            end
            S_RUN:
            begin
                cmd.run_step = 1'b1;
                if (sts.run_found)
                begin
                    state_next = S_MARK;
                end
                else if (sts.run_end)
                begin
                    cmd.q_next = retry_reg;
                    state_next = fail_state;
                end
            end
            S_MARK:
            begin
                cmd.mark_step = 1'b1;
                if (sts.mark_end)
                begin
                    state_next = S_DIRW;
                end
            end
            S_DIRW:
            begin
                cmd.dir_wr = 1'b1;
                cmd.retry  = retry_reg;
                if (retry_reg)
                begin
                    two_next   = 1'b1;
                    state_next = S_CMP_RD;
                end
                else
                begin
                    state_next = S_OUT1;
                end
            end
            S_ADD_FAIL:
            begin
                cmd.enq    = 1'b1;
                state_next = S_OUT1;
            end
            S_RM_SCAN:
            begin
                if (sts.rm_end)
                begin
                    cmd.rm_done = 1'b1;
                    state_next  = S_QTRY;
                end
                else if (sts.rm_valid)
                begin
                    state_next = S_RM_CHK;
                end
                else
                begin
                    cmd.rm_step = 1'b1;
                end
            end
            S_RM_CHK:
            begin
                cmd.rm_chk = 1'b1;
                state_next = sts.rm_match ? S_RM_FREE : S_RM_SCAN;
            end
            S_RM_FREE:
            begin
                cmd.free_step = 1'b1;
                if (sts.free_end)
                begin
                    state_next = S_RM_SCAN;
                end
            end
            S_QTRY:
            begin
                state_next = sts.q_more ? S_QLD : S_OUT1;
            end
            S_QLD:
            begin
                cmd.q_ld   = 1'b1;
                retry_next = 1'b1;
                state_next = S_DIV_GO;
            end
            S_CMP_RD:
            begin
                cmd.cmp_rd = 1'b1;
                if (sts.cmp_end)
                begin
                    cmd.cmp_done = 1'b1;
                    state_next   = S_OUT1;
                end
                else
                begin
                    state_next = S_CMP_WR;
                end
            end
            S_CMP_WR:
            begin
                cmd.cmp_wr = 1'b1;
                state_next = S_CMP_RD;
            end
            S_OUT1:
            begin
                if (!out_stall)
                begin
                    state_next = two_reg ? S_OUT2 : S_IDLE;
                end
            end
            S_OUT2:
            begin
                cmd.out_sel2 = 1'b1;
                if (!out_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            retry_reg <= 1'b0;
            two_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            retry_reg <= retry_next;
            two_reg   <= two_next;
        end
    end

    assign in_stall  = state_reg != S_IDLE;
    assign out_valid = (state_reg == S_OUT1) || (state_reg == S_OUT2);

endmodule

// ----- sim/tb_contiguous_block_allocator.sv -----
// Self-checking testbench for the first-fit contiguous block allocator.
`timescale 1ns / 1ps

module tb_contiguous_block_allocator;

    localparam int NUM_BLOCKS  = 1024;
    localparam int DIR_DEPTH   = 64;
    localparam int QUEUE_DEPTH = 16;
    // Longest correct silence: a remove that retries a full queue of scans.
    localparam int IDLE_LIMIT  = 200000;
    localparam logic [cba_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam logic                          FUNC_ADD   = 1'b0;

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_we;
    logic [cba_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [cba_pkg::CFG_DATA_W-1:0] cfg_data;
    logic                           in_valid;
    logic                           in_stall;
    logic                           func;
    logic [cba_pkg::ID_W-1:0]       file_id;
    logic [cba_pkg::SIZE_W-1:0]     file_size;
    logic                           out_valid;
    logic                           out_stall;
    logic [cba_pkg::STATUS_W-1:0]   status;
    logic [cba_pkg::ID_W-1:0]       result_id;
    logic [cba_pkg::START_W-1:0]    start_block;
    logic [cba_pkg::LEN_W-1:0]      length_blocks;
    logic                           last;

    contiguous_block_allocator #(
        .NUM_BLOCKS (NUM_BLOCKS),
        .DIR_DEPTH  (DIR_DEPTH),
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .func         (func),
        .file_id      (file_id),
        .file_size    (file_size),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .result_id    (result_id),
        .start_block  (start_block),
        .length_blocks(length_blocks),
        .last         (last)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Shadow copy of the allocator state.
    bit [NUM_BLOCKS-1:0]          disk_map;
    int                           free_blocks;
    bit                           dir_used  [DIR_DEPTH];
    logic [cba_pkg::ID_W-1:0]     dir_owner [DIR_DEPTH];
    int                           dir_first [DIR_DEPTH];
    int                           dir_len   [DIR_DEPTH];
    logic [cba_pkg::ID_W-1:0]     wait_ids  [QUEUE_DEPTH];
    logic [cba_pkg::SIZE_W-1:0]   wait_sizes[QUEUE_DEPTH];
    int                           wait_depth;
    int                           bytes_per_block;
    int                           disk_total;

    cba_pkg::res_t                pending_results[$];
    int                           fail_count;
    int                           mismatch_count;
    int                           idle_cycles;
    int                           burst_left;
    int                           stall_left;
    int                           stall_mode;
    logic [cba_pkg::ID_W-1:0]     id_pool[24];
    logic [cba_pkg::ID_W-1:0]     live_ids[$];

    function automatic int usable_blocks();
        return (disk_total < NUM_BLOCKS) ? disk_total : NUM_BLOCKS;
    endfunction

    function automatic void recount_free();
        free_blocks = 0;
        for (int i = 0; i < usable_blocks(); i++)
        begin
            if (!disk_map[i])
                free_blocks++;
        end
    endfunction

    function automatic cba_pkg::res_t make_result(logic [cba_pkg::STATUS_W-1:0] st,
                                                  logic [cba_pkg::ID_W-1:0] id,
                                                  int first, int len, logic fin);
        cba_pkg::res_t r;
        r.status = st;
        r.id     = id;
        r.start  = first[cba_pkg::START_W-1:0];
        r.len    = (len > 2047) ? cba_pkg::LEN_MAX : len[cba_pkg::LEN_W-1:0];
        r.last   = fin;
        return r;
    endfunction

    // First fit: lowest free directory slot and lowest free run of blocks.
    function automatic bit place_file(logic [cba_pkg::ID_W-1:0] id,
                                      logic [cba_pkg::SIZE_W-1:0] sz,
                                      logic [cba_pkg::STATUS_W-1:0] st,
                                      output cba_pkg::res_t r);
        int divisor;
        int need;
        int slot;
        int first;
        int run;
        bit hit;
        divisor = (bytes_per_block == 0) ? 1 : bytes_per_block;
        need    = int'(sz) / divisor;
        slot    = -1;
        first   = 0;
        hit     = 0;
        run     = 0;
        r       = '0;
        for (int d = 0; d < DIR_DEPTH; d++)
        begin
            if (!dir_used[d] && slot < 0)
                slot = d;
        end
        if (slot < 0)
            return 0;
        if (need == 0)
            hit = 1;
        else if (need <= free_blocks)
        begin
            for (int i = 0; i < usable_blocks() && !hit; i++)
            begin
                if (disk_map[i])
                    run = 0;
                else
                begin
                    run++;
                    if (run == need)
                    begin
                        first = i + 1 - need;
                        hit   = 1;
                    end
                end
            end
        end
        if (!hit)
            return 0;
        for (int k = 0; k < need; k++)
            disk_map[first + k] = 1'b1;
        dir_used[slot]  = 1'b1;
        dir_owner[slot] = id;
        dir_first[slot] = first;
        dir_len[slot]   = need;
        recount_free();
        r = make_result(st, id, first, need, 1'b1);
        return 1;
    endfunction

    function automatic void predict_request(logic f, logic [cba_pkg::ID_W-1:0] id,
                                            logic [cba_pkg::SIZE_W-1:0] sz);
        cba_pkg::res_t r;
        cba_pkg::res_t placed;
        bit            found;
        int            freed;
        bit            done;
        found = 0;
        freed = 0;
        done  = 0;
        if (f == FUNC_ADD)
        begin
            if (place_file(id, sz, cba_pkg::ST_ALLOC, r))
                pending_results.push_back(r);
            else if (wait_depth < QUEUE_DEPTH)
            begin
                wait_ids[wait_depth]   = id;
                wait_sizes[wait_depth] = sz;
                wait_depth++;
                pending_results.push_back(make_result(cba_pkg::ST_QUEUED, id, 0, 0, 1'b1));
            end
            else
                pending_results.push_back(make_result(cba_pkg::ST_DROPPED, id, 0, 0, 1'b1));
            return;
        end
        for (int d = 0; d < DIR_DEPTH; d++)
        begin
            if (dir_used[d] && dir_owner[d] == id)
            begin
                for (int k = 0; k < dir_len[d]; k++)
                begin
                    if (dir_first[d] + k < NUM_BLOCKS)
                        disk_map[dir_first[d] + k] = 1'b0;
                end
                freed += dir_len[d];
                dir_used[d] = 1'b0;
                found = 1;
            end
        end
        recount_free();
        r = make_result(found ? cba_pkg::ST_REMOVED : cba_pkg::ST_NOT_FOUND, id, 0,
                        found ? freed : 0, 1'b1);
        // Retry the wait queue in order; the first one that fits leaves it.
        for (int q = 0; q < wait_depth && !done; q++)
        begin
            if (place_file(wait_ids[q], wait_sizes[q], cba_pkg::ST_PLACED, placed))
            begin
                for (int m = q; m + 1 < wait_depth; m++)
                begin
                    wait_ids[m]   = wait_ids[m + 1];
                    wait_sizes[m] = wait_sizes[m + 1];
                end
                wait_depth--;
                done = 1;
            end
        end
        if (done)
        begin
            r.last = 1'b0;
            pending_results.push_back(r);
            pending_results.push_back(placed);
        end
        else
            pending_results.push_back(r);
    endfunction

    // Drive one request beat; hold valid across a burst, drop it for a gap.
    task automatic send_request(logic f, logic [cba_pkg::ID_W-1:0] id,
                                logic [cba_pkg::SIZE_W-1:0] sz);
        @(negedge clk);
        in_valid  <= 1'b1;
        func      <= f;
        file_id   <= id;
        file_size <= sz;
        do
            @(posedge clk);
        while (in_stall);
        predict_request(f, id, sz);
        if (f == FUNC_ADD)
            live_ids.push_back(id);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat ($urandom_range(0, 6)) @(negedge clk);
            burst_left = $urandom_range(0, 5);
        end
    endtask

    // Wait until the block is idle, then write one register.
    task automatic write_register(logic [cba_pkg::CFG_IDX_W-1:0] idx,
                                  logic [cba_pkg::CFG_DATA_W-1:0] value);
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == cba_pkg::REG_BLOCK_BYTES)
            bytes_per_block = int'(value);
        else if (idx == cba_pkg::REG_TOTAL_BLOCKS)
        begin
            disk_total = int'(value[cba_pkg::TOTAL_W-1:0]);
            recount_free();
        end
    endtask

    task automatic set_disk(int bb, int total);
        write_register(cba_pkg::REG_BLOCK_BYTES, bb[cba_pkg::CFG_DATA_W-1:0]);
        write_register(cba_pkg::REG_TOTAL_BLOCKS, total[cba_pkg::CFG_DATA_W-1:0]);
    endtask

    function automatic logic [cba_pkg::SIZE_W-1:0] bytes_for(int blocks);
        longint b;
        int     divisor;
        divisor = (bytes_per_block == 0) ? 1 : bytes_per_block;
        b = longint'(blocks) * divisor + $urandom_range(0, divisor - 1);
        return (b > 24'hFFFFFF) ? 24'hFFFFFF : b[cba_pkg::SIZE_W-1:0];
    endfunction

    // Extremes of ids and sizes, zero-length files, oversize, unknown id.
    task automatic test_field_extremes();
        send_request(FUNC_ADD, 16'h0000, 24'd0);
        send_request(FUNC_ADD, 16'hFFFF, 24'd1023);
        send_request(FUNC_ADD, 16'h0001, 24'hFFFFFF);
        send_request(FUNC_ADD, 16'h0002, 24'd512 * 24'd1000);
        send_request(cba_pkg::FUNC_REMOVE, 16'hFFFF, 24'hFFFFFF);
        send_request(cba_pkg::FUNC_REMOVE, 16'h1234, 24'd0);
        send_request(cba_pkg::FUNC_REMOVE, 16'h0002, 24'd0);
        send_request(FUNC_ADD, 16'h0002, 24'd512 * 24'd3);
        send_request(FUNC_ADD, 16'h0002, 24'd512 * 24'd4);
        send_request(cba_pkg::FUNC_REMOVE, 16'h0002, 24'd0);
    endtask

    // Zero divisor, zero and oversized totals, ignored register index.
    task automatic test_register_extremes();
        set_disk(0, 0);
        send_request(FUNC_ADD, 16'h0040, 24'd0);
        send_request(FUNC_ADD, 16'h0041, 24'd5);
        write_register(REG_UNUSED, 16'hFFFF);
        write_register(cba_pkg::REG_TOTAL_BLOCKS, 16'd2047);
        send_request(cba_pkg::FUNC_REMOVE, 16'h0040, 24'd0);
        set_disk(65535, 1);
        send_request(FUNC_ADD, 16'h0042, 24'hFFFFFF);
        send_request(FUNC_ADD, 16'h0043, 24'd65535);
        send_request(cba_pkg::FUNC_REMOVE, 16'h0043, 24'd0);
        send_request(cba_pkg::FUNC_REMOVE, 16'h0041, 24'd0);
    endtask

    // Fill the wait queue until adds get dropped, then let removes place queued files.
    task automatic test_queue_full();
        set_disk(1, 8);
        send_request(FUNC_ADD, 16'h0100, 24'd8);
        for (int i = 0; i < QUEUE_DEPTH + 2; i++)
            send_request(FUNC_ADD, 16'h0200 + i[cba_pkg::ID_W-1:0],
                         24'd9 + i[cba_pkg::SIZE_W-1:0]);
        send_request(cba_pkg::FUNC_REMOVE, 16'h0100, 24'd0);
        set_disk(1, 1024);
        for (int i = 0; i < 4; i++)
            send_request(cba_pkg::FUNC_REMOVE, 16'h7777, 24'd0);
    endtask

    // Fill every directory slot with zero-length files, then free every fourth one.
    task automatic test_directory_full();
        set_disk(512, 1024);
        for (int i = 0; i < DIR_DEPTH + 2; i++)
            send_request(FUNC_ADD, 16'h0300 + i[cba_pkg::ID_W-1:0], 24'd100);
        for (int i = 0; i < DIR_DEPTH + 2; i += 4)
            send_request(cba_pkg::FUNC_REMOVE, 16'h0300 + i[cba_pkg::ID_W-1:0], 24'd0);
    endtask

    // Mostly well-formed add/remove traffic on a pool of ids, plus noise.
    task automatic test_random_traffic(int bb, int total, int count);
        int                        pick;
        logic [cba_pkg::ID_W-1:0]  id;
        set_disk(bb, total);
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
            begin
                id = ($urandom_range(0, 9) < 8) ? id_pool[$urandom_range(0, 23)]
                                                 : cba_pkg::ID_W'($urandom);
                pick = $urandom_range(0, 9);
                if (pick < 8)
                    send_request(FUNC_ADD, id, bytes_for($urandom_range(0, total / 8 + 2)));
                else if (pick < 9)
                    send_request(FUNC_ADD, id, bytes_for($urandom_range(0, 1200)));
                else
                    send_request(FUNC_ADD, id, cba_pkg::SIZE_W'($urandom));
            end
            else
            begin
                if (live_ids.size() > 0 && $urandom_range(0, 3) != 0)
                    id = live_ids[$urandom_range(0, live_ids.size() - 1)];
                else
                    id = cba_pkg::ID_W'($urandom);
                send_request(cba_pkg::FUNC_REMOVE, id, cba_pkg::SIZE_W'($urandom));
            end
        end
    endtask

    // Result checker: compare each accepted beat with the oldest expectation.
    always @(posedge clk)
    begin
        cba_pkg::res_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                fail_count++;
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected beat: status=%0d id=%h", status, result_id);
            end
            else
            begin
                want = pending_results.pop_front();
                if (status !== want.status || result_id !== want.id ||
                    start_block !== want.start || length_blocks !== want.len ||
                    last !== want.last)
                begin
                    fail_count++;
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"mismatch: exp st=%0d id=%h start=%0d len=%0d last=%0d,",
                                  " got st=%0d id=%h start=%0d len=%0d last=%0d"},
                                 want.status, want.id, want.start, want.len, want.last,
                                 status, result_id, start_block, length_blocks, last);
                end
            end
        end
    end

    // Receiver back-pressure: switch between patterns, including no stall.
    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(5, 40);
        end
        stall_left--;
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= $urandom_range(0, 1);
            2: out_stall <= ($urandom_range(0, 3) == 0);
            default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
    end

    // Watchdog: cycles with no beat on either channel.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles > IDLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        clk             = 1'b0;
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        in_valid        = 1'b0;
        func            = FUNC_ADD;
        file_id         = '0;
        file_size       = '0;
        out_stall       = 1'b0;
        fail_count      = 0;
        mismatch_count  = 0;
        idle_cycles     = 0;
        burst_left      = 0;
        stall_left      = 0;
        stall_mode      = 0;
        disk_map        = '0;
        wait_depth      = 0;
        bytes_per_block = int'(cba_pkg::BB_RESET);
        disk_total      = int'(cba_pkg::TOTAL_RESET);
        for (int d = 0; d < DIR_DEPTH; d++)
            dir_used[d] = 1'b0;
        for (int i = 0; i < 24; i++)
            id_pool[i] = cba_pkg::ID_W'($urandom);
        recount_free();
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        test_field_extremes();
        test_register_extremes();
        test_queue_full();
        test_directory_full();
        test_random_traffic(512, 1024, 60);
        test_random_traffic(1, 64, 40);
        test_random_traffic(65535, 2047, 20);
        test_random_traffic(300, 200, 30);
        test_random_traffic($urandom_range(1, 65535), $urandom_range(1, 1024), 20);

        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (50) @(posedge clk);
        if (pending_results.size() != 0)
            fail_count++;
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
